>>> hdl/pcpfla_pkg.sv
// ----------------------------------------------------------------------------
// pcpfla_pkg
// Shared widths, codes and item types of the per-cpu page free list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pcpfla_pkg;

  localparam int ADDR_W     = 56;
  localparam int CPUS       = 3;
  localparam int NUM_PAGES  = 32768;
  localparam int PAGE_BYTES = 4096;

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int PG_W       = ADDR_W - PAGE_SHIFT;
  localparam int IDX_W      = $clog2(NUM_PAGES);
  localparam int LIST_W     = (CPUS > 1) ? $clog2(CPUS) : 1;

  localparam int KIND_W    = 2;
  localparam int CPU_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INIT  = 2'd2;

  // result status
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_LIMIT  = 1'd1;

  localparam logic [63:0] FIRST_FREE_RST = 64'h0000_0000_8000_0000;
  localparam logic [63:0] MEM_LIMIT_RST  = 64'h0000_0000_8800_0000;
  // first managed page number, first free address rounded up to a page
  localparam logic [63:0] BASE_PG_RST    = (FIRST_FREE_RST + PAGE_BYTES - 1) / PAGE_BYTES;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CPU_W-1:0]  cpu;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   page_address;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  // one entry of the next-link memory
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] nxt;
  } link_t;

  localparam int LINK_W = $bits(link_t);

endpackage

`default_nettype wire

>>> hdl/pcpfla_link_ram.sv
// ----------------------------------------------------------------------------
// pcpfla_link_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pcpfla_link_ram #(
  parameter int DEPTH = 32768,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/per_cpu_page_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// per_cpu_page_free_list_allocator_top
// Per-cpu LIFO page free lists linked through a next-link memory.
// ----------------------------------------------------------------------------
// The result strobes in the cycle after the item is taken.
// No new item is taken while busy; busy is high for the cycle in which the
// link memory read data returns and the list head is written back.
// Reset clears all list valid bits and the init rotation at once; the link
// memory needs no clearing pass since a link is only read after being written.
// Results cannot be stalled by the receiver.
`default_nettype none

module per_cpu_page_free_list_allocator_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  pcpfla_pkg::in_item_t                in_item,
  output logic                                busy,
  output logic                                out_valid,
  output pcpfla_pkg::out_item_t               out_item,
  input  logic                                cfg_we,
  input  logic [pcpfla_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcpfla_pkg::ADDR_W-1:0]       cfg_data
);

  import pcpfla_pkg::*;

  typedef struct packed {
    logic              found;
    logic [LIST_W-1:0] list;
  } pick_t;

  function automatic logic [LIST_W-1:0] wrap_cpu(input logic [CPU_W-1:0] cpu);
    logic [3:0] v;
    v = 4'(cpu);
    if (CPUS == 1) begin
      v = '0;
    end else if (v >= 4'(CPUS)) begin
      v = v - 4'(CPUS);
    end
    return v[LIST_W-1:0];
  endfunction

  // first non-empty list in cyclic order from the requester
  function automatic pick_t pick_list(input logic [LIST_W-1:0] first,
                                      input logic [CPUS-1:0]   vld);
    pick_t       res;
    logic [LIST_W:0] cand;
    res  = '0;
    cand = '0;
    for (int k = CPUS - 1; k >= 0; k--) begin
      cand = {1'b0, first} + (LIST_W + 1)'(k);
      if (cand >= (LIST_W + 1)'(CPUS)) begin
        cand = cand - (LIST_W + 1)'(CPUS);
      end
      if (vld[cand[LIST_W-1:0]]) begin
        res.found = 1'b1;
        res.list  = cand[LIST_W-1:0];
      end
    end
    return res;
  endfunction

  logic              busy_r, busy_nxt;
  in_item_t          req_r;
  pick_t             pop_r;
  logic [IDX_W-1:0]  head_r [CPUS];
  logic [CPUS-1:0]   head_vld_r;
  logic [LIST_W-1:0] rot_r, rot_nxt;
  logic [PG_W:0]     base_pg_r;
  logic [ADDR_W-1:0] limit_r;

  logic              accept;
  pick_t             pick;
  logic [LIST_W-1:0] req_list;
  logic [LIST_W-1:0] push_list;
  logic [LIST_W-1:0] head_sel;
  logic [IDX_W-1:0]  head_q;
  logic [PG_W:0]     addr_pg;
  logic [PG_W:0]     pg_diff;
  logic [PG_W:0]     pg_sum;
  logic              addr_ok;
  logic [IDX_W-1:0]  push_idx;
  logic              do_push;
  logic              do_pop;
  logic [ADDR_W:0]   base_rnd;
  link_t             link_wr;
  link_t             link_rd;

  assign accept   = start & ~busy_r;
  assign pick     = pick_list(wrap_cpu(in_item.cpu), head_vld_r);
  assign req_list = wrap_cpu(req_r.cpu);
  assign push_list = (req_r.kind == KIND_INIT) ? rot_r : req_list;

  // one head read port: pop pick while idle, push list while busy
  assign head_sel = busy_r ? push_list : pick.list;
  assign head_q   = head_r[head_sel];

  // address check on page numbers, the base is already page aligned
  assign addr_pg  = {1'b0, req_r.address[ADDR_W-1:PAGE_SHIFT]};
  assign pg_diff  = addr_pg - base_pg_r;
  assign addr_ok  = (req_r.address[PAGE_SHIFT-1:0] == '0) &&
                    (addr_pg >= base_pg_r) &&
                    (req_r.address < limit_r) &&
                    (pg_diff < (PG_W + 1)'(NUM_PAGES));
  assign push_idx = pg_diff[IDX_W-1:0];

  assign do_push = busy_r && addr_ok &&
                   ((req_r.kind == KIND_FREE) || (req_r.kind == KIND_INIT));
  assign do_pop  = busy_r && (req_r.kind == KIND_ALLOC) && pop_r.found;

  assign link_wr.vld = head_vld_r[push_list];
  assign link_wr.nxt = head_q;

  pcpfla_link_ram #(
    .DEPTH (NUM_PAGES),
    .WIDTH (LINK_W)
  ) u_link_ram (
    .clk   (clk),
    .we    (do_push),
    .waddr (push_idx),
    .wdata (link_wr),
    .re    (accept),
    .raddr (head_q),
    .rdata (link_rd)
  );

  always_comb begin
    busy_nxt = accept;
    rot_nxt  = rot_r;
    if (do_push && (req_r.kind == KIND_INIT)) begin
      rot_nxt = (rot_r == LIST_W'(CPUS - 1)) ? '0 : rot_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      head_vld_r <= '0;
      rot_r      <= '0;
      base_pg_r  <= BASE_PG_RST[PG_W:0];
      limit_r    <= MEM_LIMIT_RST[ADDR_W-1:0];
    end else begin
      busy_r <= busy_nxt;
      rot_r  <= rot_nxt;
      if (do_pop) begin
        head_vld_r[pop_r.list] <= link_rd.vld;
      end
      if (do_push) begin
        head_vld_r[push_list] <= 1'b1;
      end
      if (cfg_we && (cfg_index == CFG_FIRST_FREE)) begin
        base_pg_r <= base_rnd[ADDR_W:PAGE_SHIFT];
      end
      if (cfg_we && (cfg_index == CFG_MEM_LIMIT)) begin
        limit_r <= cfg_data;
      end
    end
  end

  assign base_rnd = {1'b0, cfg_data} + (ADDR_W + 1)'(PAGE_BYTES - 1);

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_item;
      pop_r <= pick;
    end
    if (do_pop) begin
      head_r[pop_r.list] <= link_rd.nxt;
    end
    if (do_push) begin
      head_r[push_list] <= push_idx;
    end
  end

  assign pg_sum = base_pg_r + (PG_W + 1)'(head_r[pop_r.list]);

  always_comb begin
    out_item        = '0;
    out_item.status = STATUS_DONE;
    case (req_r.kind)
      KIND_ALLOC: begin
        if (pop_r.found) begin
          out_item.page_address = {pg_sum[PG_W-1:0], {PAGE_SHIFT{1'b0}}};
        end else begin
          out_item.status = STATUS_EMPTY;
        end
      end
      KIND_FREE, KIND_INIT: begin
        if (!addr_ok) begin
          out_item.status = STATUS_BAD;
        end
      end
      default: begin
        out_item.status = STATUS_DONE;
      end
    endcase
  end

  assign out_valid = busy_r;
  assign busy      = busy_r;

endmodule

`default_nettype wire

>>> hdl/pcpfla_checker.sv
// ----------------------------------------------------------------------------
// pcpfla_checker
// Port-level timing and result checks of the page allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pcpfla_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input pcpfla_pkg::in_item_t  in_item,
  input logic                  out_valid,
  input pcpfla_pkg::out_item_t out_item
);

  import pcpfla_pkg::*;

  // every taken item gives its result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && out_valid))
    else $error("no result after a taken item");

  // exactly one result per item
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held over two cycles");

  // busy lasts one cycle only
  a_busy_short: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held over two cycles");

  // free and init items never return a page
  a_free_no_page: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.kind != KIND_ALLOC)) |=> (out_item.page_address == '0))
    else $error("page address on a non-allocate item");

  a_empty_no_page: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status == STATUS_EMPTY)) |-> (out_item.page_address == '0))
    else $error("page address with empty status");

endmodule

bind per_cpu_page_free_list_allocator_top pcpfla_checker u_pcpfla_checker (.*);

`default_nettype wire
